### hdl/dhec_pkg.sv
// Shared types and constants for the deadline heap expiry counter.
package dhec_pkg;

    // Field widths fixed by the item format
    localparam int TIME_W = 63;
    localparam int CNT_W  = 7;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UPCMP,
        S_ROOT,
        S_ROOTCMP,
        S_LAST,
        S_DN,
        S_DNL,
        S_DNR,
        S_DNMV,
        S_DONE
    } t_state;

endpackage

### hdl/dhec_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dhec_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/deadline_heap_expiry_counter.sv
// Top level: binary min-heap of deadlines with a sequencer around one shared comparator.
// Deadlines sit in a HEAP_DEPTH-entry RAM organized as a binary min-heap; one 63-bit
// less-than comparator, time-shared under a small sequencer, does every heap compare.
// The block takes one item at a time and holds o_in_stall high until its result is in the
// output register; a pending result does not block the next item from being taken.
// A rejected insert goes straight to the result. An insert opens a hole at the
// end of the heap, reads each parent in turn and moves it down while the new
// deadline is smaller, then writes the deadline into the hole. A tick compares
// the root with the tick time until the root has not expired or the heap is
// empty; each expired deadline that leaves entries behind fetches the last entry
// to refill the root, which then sifts down with a left read, a right read if
// there is a right child, and a move or stop at each level. The single RAM read
// port, one access per cycle, is why these steps run one after another. The RAM
// contents need no clearing after reset: only entries below the held count are read.
module deadline_heap_expiry_counter #(
    parameter int HEAP_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [62:0]           i_time_value,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [6:0]            o_expired_count,
    output logic                  o_insert_rejected,
    output logic [6:0]            o_entries_held
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int CW = AW + 2;

    dhec_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_size, n_size;
    logic [SW-1:0]    r_cnt, n_cnt;
    logic             r_rej, n_rej;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_cidx, n_cidx;
    logic             r_best, n_best;
    dhec_pkg::t_time  r_time, n_time;
    dhec_pkg::t_time  r_hold, n_hold;
    dhec_pkg::t_time  r_child, n_child;

    logic             r_out_valid, n_out_valid;
    dhec_pkg::t_cnt   r_out_cnt, n_out_cnt;
    logic             r_out_rej, n_out_rej;
    dhec_pkg::t_cnt   r_out_held, n_out_held;

    // RAM port signals
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    dhec_pkg::t_time  ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    dhec_pkg::t_time  ram_rd_data;

    // Shared comparator
    dhec_pkg::t_time  cmp_a, cmp_b;
    logic             cmp_lt;

    // Heap index arithmetic
    logic [AW-1:0]    parent_idx;
    logic [CW-1:0]    left_idx, right_idx;
    logic [SW-1:0]    size_dec;

    logic             in_accept;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != dhec_pkg::S_IDLE);

    assign parent_idx = AW'((r_pos - AW'(1)) >> 1);
    assign left_idx   = CW'((CW'(r_pos) << 1) + CW'(1));
    assign right_idx  = CW'(left_idx + CW'(1));
    assign size_dec   = SW'(r_size - SW'(1));

    assign cmp_lt = (cmp_a < cmp_b);

    dhec_ram #(
        .WIDTH (dhec_pkg::TIME_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Comparator operand select
    always_comb begin
        cmp_a = ram_rd_data;
        cmp_b = r_hold;
        case (r_state)
            dhec_pkg::S_UPCMP: begin
                // new deadline below parent means it keeps rising
                cmp_a = r_hold;
                cmp_b = ram_rd_data;
            end
            dhec_pkg::S_ROOTCMP: begin
                cmp_a = ram_rd_data;
                cmp_b = r_time;
            end
            dhec_pkg::S_DNR: begin
                cmp_a = ram_rd_data;
                cmp_b = r_best ? r_child : r_hold;
            end
            default: begin
                cmp_a = ram_rd_data;
                cmp_b = r_hold;
            end
        endcase
    end

    // Control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dhec_pkg::S_IDLE;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_rej      <= n_rej;
        r_pos      <= n_pos;
        r_cidx     <= n_cidx;
        r_best     <= n_best;
        r_time     <= n_time;
        r_hold     <= n_hold;
        r_child    <= n_child;
        r_out_cnt  <= n_out_cnt;
        r_out_rej  <= n_out_rej;
        r_out_held <= n_out_held;
    end

    // Sequencer: next state, RAM control, working registers
    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_cnt       = r_cnt;
        n_rej       = r_rej;
        n_pos       = r_pos;
        n_cidx      = r_cidx;
        n_best      = r_best;
        n_time      = r_time;
        n_hold      = r_hold;
        n_child     = r_child;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_cnt   = r_out_cnt;
        n_out_rej   = r_out_rej;
        n_out_held  = r_out_held;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_pos;
        ram_wr_data = r_hold;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_pos;

        case (r_state)
            dhec_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_time = i_time_value;
                    n_hold = i_time_value;
                    n_cnt  = '0;
                    n_rej  = 1'b0;
                    if (i_req_type == dhec_pkg::REQ_TICK) begin
                        n_state = dhec_pkg::S_ROOT;
                    end else if (r_size == SW'(HEAP_DEPTH)) begin
                        n_rej   = 1'b1;
                        n_state = dhec_pkg::S_DONE;
                    end else begin
                        // open a hole at the end of the heap
                        n_pos   = r_size[AW-1:0];
                        n_size  = SW'(r_size + SW'(1));
                        n_state = dhec_pkg::S_UP;
                    end
                end
            end

            // sift up: move the hole toward the root
            dhec_pkg::S_UP: begin
                if (r_pos == '0) begin
                    ram_wr_en = 1'b1;
                    n_state   = dhec_pkg::S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = parent_idx;
                    n_state     = dhec_pkg::S_UPCMP;
                end
            end

            dhec_pkg::S_UPCMP: begin
                ram_wr_en = 1'b1;
                if (cmp_lt) begin
                    ram_wr_data = ram_rd_data;
                    n_pos       = parent_idx;
                    n_state     = dhec_pkg::S_UP;
                end else begin
                    n_state = dhec_pkg::S_DONE;
                end
            end

            // tick: look at the earliest deadline
            dhec_pkg::S_ROOT: begin
                if (r_size == '0) begin
                    n_state = dhec_pkg::S_DONE;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    n_state     = dhec_pkg::S_ROOTCMP;
                end
            end

            dhec_pkg::S_ROOTCMP: begin
                if (!cmp_lt) begin
                    n_state = dhec_pkg::S_DONE;
                end else begin
                    n_cnt  = SW'(r_cnt + SW'(1));
                    n_size = size_dec;
                    if (size_dec == '0) begin
                        n_state = dhec_pkg::S_ROOT;
                    end else begin
                        // fetch the last entry to refill the root
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = size_dec[AW-1:0];
                        n_state     = dhec_pkg::S_LAST;
                    end
                end
            end

            dhec_pkg::S_LAST: begin
                n_hold  = ram_rd_data;
                n_pos   = '0;
                n_state = dhec_pkg::S_DN;
            end

            // sift down: pick the smaller child, ties favor the hole then the left
            dhec_pkg::S_DN: begin
                n_best = 1'b0;
                if (left_idx >= CW'(r_size)) begin
                    ram_wr_en = 1'b1;
                    n_state   = dhec_pkg::S_ROOT;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = left_idx[AW-1:0];
                    n_state     = dhec_pkg::S_DNL;
                end
            end

            dhec_pkg::S_DNL: begin
                if (cmp_lt) begin
                    n_best  = 1'b1;
                    n_child = ram_rd_data;
                    n_cidx  = left_idx[AW-1:0];
                end
                if (right_idx < CW'(r_size)) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = right_idx[AW-1:0];
                    n_state     = dhec_pkg::S_DNR;
                end else begin
                    n_state = dhec_pkg::S_DNMV;
                end
            end

            dhec_pkg::S_DNR: begin
                if (cmp_lt) begin
                    n_best  = 1'b1;
                    n_child = ram_rd_data;
                    n_cidx  = right_idx[AW-1:0];
                end
                n_state = dhec_pkg::S_DNMV;
            end

            dhec_pkg::S_DNMV: begin
                ram_wr_en = 1'b1;
                if (r_best) begin
                    ram_wr_data = r_child;
                    n_pos       = r_cidx;
                    n_state     = dhec_pkg::S_DN;
                end else begin
                    n_state = dhec_pkg::S_ROOT;
                end
            end

            // hand the result to the output register once it is free
            dhec_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = dhec_pkg::CNT_W'(r_cnt);
                    n_out_rej   = r_rej;
                    n_out_held  = dhec_pkg::CNT_W'(r_size);
                    n_state     = dhec_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = dhec_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_expired_count   = r_out_cnt;
    assign o_insert_rejected = r_out_rej;
    assign o_entries_held    = r_out_held;

endmodule

### hdl/dhec_checker.sv
// Port-level checker for the deadline heap expiry counter, with its bind.
module dhec_checker #(
    parameter int HEAP_DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [6:0]  o_expired_count,
    input logic        o_insert_rejected,
    input logic [6:0]  o_entries_held
);

    // a reset leaves no result showing
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block ready right after taking an item");

    // a rejected insert only happens on a full heap and expires nothing
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_insert_rejected |->
            o_expired_count == 7'd0 && o_entries_held == 7'(HEAP_DEPTH))
        else $error("insert rejected while heap not full");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_expired_count) && $stable(o_insert_rejected)
            && $stable(o_entries_held))
        else $error("stalled result changed");

endmodule

bind deadline_heap_expiry_counter dhec_checker #(
    .HEAP_DEPTH (HEAP_DEPTH)
) u_dhec_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_expired_count   (o_expired_count),
    .o_insert_rejected (o_insert_rejected),
    .o_entries_held    (o_entries_held)
);
